FILE: rtl/ipsu_pkg.sv
package ipsu_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int CHANNELS     = 8461;
  localparam int COLUMNS      = 60;
  localparam int QUEUE_DEPTH  = 2;

  localparam int WORD_BITS  = 16;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [15:0] MIN_PAYLOAD      = 16'd8954;
  localparam logic [7:0]  LAST_COUNTER     = 8'd30;
  localparam logic [10:0] SRC_BOTH_OFFSETS = 11'd130;
  localparam logic [10:0] SRC_COL_OFFSET   = 11'd135;
  localparam logic [10:0] SRC_ROW_OFFSET   = 11'd140;

  localparam logic [4:0]  SEG_COUNT_RESET = 5'd1;
  localparam logic [13:0] SPS_RESET       = 14'd8461;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTHS    = 2'd2;

  typedef struct packed {
    logic        is_hdr;
    logic        ok;
    logic        step;
    logic        row_off;
    logic        col_off;
    logic [4:0]  cnt;
    logic [15:0] word;
    logic        lastw;
  } item_t;

  function automatic logic [4:0] field_width(input logic [63:0] widths,
                                             input logic [3:0] idx);
    field_width = {1'b0, widths[{idx, 2'b00} +: 4]} + 5'd1;
  endfunction

endpackage

FILE: rtl/ipsu_front.sv
module ipsu_front
  import ipsu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  output logic                 f_valid,
  output item_t                f_item,
  input  logic                 f_ready
);

  logic  f_valid_r;
  item_t f_item_r;
  item_t cls;

  logic [10:0] src;
  logic [7:0]  cnt;
  logic [15:0] len;

  assign src = in_tdata[10:0];
  assign cnt = in_tdata[18:11];
  assign len = in_tdata[34:19];

  always_comb begin
    cls.is_hdr  = (in_tuser == CMD_HEADER);
    cls.ok      = (len >= MIN_PAYLOAD) && (cnt >= 8'd1) && (cnt <= LAST_COUNTER);
    cls.step    = cls.ok && (cnt == LAST_COUNTER) && (src == SRC_BOTH_OFFSETS);
    cls.row_off = (src == SRC_BOTH_OFFSETS) || (src == SRC_ROW_OFFSET);
    cls.col_off = (src == SRC_BOTH_OFFSETS) || (src == SRC_COL_OFFSET);
    cls.cnt     = cnt[4:0];
    cls.word    = in_tdata[50:35];
    cls.lastw   = in_tlast;
  end

  assign in_tready = !f_valid_r || f_ready;
  assign f_valid   = f_valid_r;
  assign f_item    = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_tready) begin
      f_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      f_item_r <= cls;
    end
  end

endmodule

FILE: rtl/ipsu_queue.sv
module ipsu_queue
  import ipsu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  head_valid,
  output item_t head_item,
  input  logic  pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/ipsu_back.sv
module ipsu_back
  import ipsu_pkg::*;
#(
  parameter int MAX_SEGMENTS = ipsu_pkg::MAX_SEGMENTS,
  parameter int CHANNELS     = ipsu_pkg::CHANNELS,
  parameter int COLUMNS      = ipsu_pkg::COLUMNS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam logic [5:0] COL_TOP = 6'((COLUMNS - 1) % 64);

  logic [4:0]  segcnt_r;
  logic [13:0] sps_r;
  logic [63:0] widths_r;

  logic [15:0] line_r, line_nxt;
  logic        active_r, active_nxt;
  logic        row_off_r, row_off_nxt;
  logic        col_off_r, col_off_nxt;
  logic [4:0]  held_r, held_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] part_r, part_nxt;
  logic [3:0]  pbits_r, pbits_nxt;
  logic [3:0]  seg_r, seg_nxt;
  logic [13:0] sis_r, sis_nxt;
  logic [13:0] ch_r, ch_nxt;
  logic [3:0]  pos_r, pos_nxt;

  logic        out_valid_r;
  logic [13:0] out_ch_r;
  logic [15:0] out_row_r;
  logic [5:0]  out_col_r;
  logic [15:0] out_smp_r;
  logic        out_last_r;

  logic [4:0]  nseg;
  logic        cfg_bad;
  logic [4:0]  w, avail, need, take, pos_new, w_next;
  logic        fits;
  logic [15:0] shifted, bits_new, part_new, smp_val;
  logic [16:0] mask17;
  logic        emit_ok, seg_end, pkt_end, emit_last;
  logic [13:0] ch_inc, sis_inc;
  logic [3:0]  next_seg;
  logic        out_free, go, out_load, done;

  assign nseg    = (segcnt_r > 5'(MAX_SEGMENTS)) ? 5'(MAX_SEGMENTS) : segcnt_r;
  assign cfg_bad = (nseg == 5'd0) || (sps_r == 14'd0) || ({1'b0, seg_r} >= nseg);

  assign w        = field_width(widths_r, seg_r);
  assign avail    = 5'd16 - {1'b0, pos_r};
  assign need     = ({1'b0, pbits_r} >= w) ? 5'd1 : w - {1'b0, pbits_r};
  assign fits     = (avail >= need);
  assign take     = fits ? need : avail;
  assign shifted  = q_item.word >> pos_r;
  assign mask17   = (17'd1 << take) - 17'd1;
  assign bits_new = shifted & mask17[15:0];
  assign part_new = part_r | (bits_new << pbits_r);
  assign smp_val  = part_new << (5'd16 - w);
  assign pos_new  = {1'b0, pos_r} + take;

  assign emit_ok  = (ch_r < 14'(CHANNELS));
  assign ch_inc   = emit_ok ? ch_r + 14'd1 : ch_r;
  assign sis_inc  = sis_r + 14'd1;
  assign seg_end  = (sis_inc >= sps_r);
  assign pkt_end  = seg_end && (({1'b0, seg_r} + 5'd1) >= nseg);
  assign next_seg = seg_end ? seg_r + 4'd1 : seg_r;
  assign w_next   = field_width(widths_r, next_seg);
  assign emit_last = (ch_inc >= 14'(CHANNELS)) || pkt_end || ((5'd16 - pos_new) < w_next);

  assign out_free = !out_valid_r || out_tready;
  assign go       = q_valid && (q_item.is_hdr || out_free);
  assign out_load = go && !q_item.is_hdr && active_r && !cfg_bad && fits && emit_ok;

  always_comb begin
    line_nxt    = line_r;
    active_nxt  = active_r;
    row_off_nxt = row_off_r;
    col_off_nxt = col_off_r;
    held_nxt    = held_r;
    pend_nxt    = pend_r;
    part_nxt    = part_r;
    pbits_nxt   = pbits_r;
    seg_nxt     = seg_r;
    sis_nxt     = sis_r;
    ch_nxt      = ch_r;
    pos_nxt     = pos_r;
    done        = 1'b1;
    if (go) begin
      if (q_item.is_hdr) begin
        line_nxt    = line_r + (pend_r ? 16'd2 : 16'd0);
        part_nxt    = '0;
        pbits_nxt   = '0;
        seg_nxt     = '0;
        sis_nxt     = '0;
        ch_nxt      = '0;
        pos_nxt     = '0;
        row_off_nxt = q_item.row_off;
        col_off_nxt = q_item.col_off;
        held_nxt    = q_item.cnt;
        active_nxt  = q_item.ok && (nseg != 5'd0) && (sps_r != 14'd0);
        pend_nxt    = q_item.step;
      end else begin
        if (active_r && !cfg_bad) begin
          if (fits) begin
            part_nxt  = '0;
            pbits_nxt = '0;
            ch_nxt    = ch_inc;
            if (seg_end) begin
              sis_nxt = '0;
              seg_nxt = seg_r + 4'd1;
              if (pkt_end) begin
                active_nxt = 1'b0;
              end
            end else begin
              sis_nxt = sis_inc;
            end
            pos_nxt = pos_new[3:0];
            done    = (pos_new == 5'd16) || pkt_end;
          end else begin
            part_nxt  = part_new;
            pbits_nxt = pbits_r + take[3:0];
          end
        end else begin
          active_nxt = 1'b0;
        end
        if (done) begin
          pos_nxt = '0;
          if (q_item.lastw) begin
            active_nxt = 1'b0;
            line_nxt   = line_r + (pend_r ? 16'd2 : 16'd0);
            pend_nxt   = 1'b0;
          end
        end
      end
    end
  end

  assign q_pop = go && (q_item.is_hdr || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segcnt_r    <= SEG_COUNT_RESET;
      sps_r       <= SPS_RESET;
      widths_r    <= '1;
      line_r      <= '0;
      active_r    <= 1'b0;
      row_off_r   <= 1'b0;
      col_off_r   <= 1'b0;
      held_r      <= '0;
      pend_r      <= 1'b0;
      part_r      <= '0;
      pbits_r     <= '0;
      seg_r       <= '0;
      sis_r       <= '0;
      ch_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEG_COUNT: segcnt_r <= cfg_wdata[4:0];
          CFG_SPS:       sps_r    <= cfg_wdata[13:0];
          CFG_WIDTHS:    widths_r <= cfg_wdata;
          default: ;
        endcase
      end
      line_r      <= line_nxt;
      active_r    <= active_nxt;
      row_off_r   <= row_off_nxt;
      col_off_r   <= col_off_nxt;
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      part_r      <= part_nxt;
      pbits_r     <= pbits_nxt;
      seg_r       <= seg_nxt;
      sis_r       <= sis_nxt;
      ch_r        <= ch_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= ch_r;
      out_row_r  <= line_r + {15'd0, row_off_r};
      out_col_r  <= COL_TOP - {held_r, 1'b0} + 6'd2 - {5'd0, col_off_r};
      out_smp_r  <= smp_val;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_smp_r, out_col_r, out_row_r, out_ch_r};

endmodule

FILE: rtl/instrument_packet_sample_unpacker.sv
// Unpacks instrument packet payloads into left-justified samples tagged with channel,
// image row and column. Input beats first pass an ingress register and a two-entry queue,
// so the input keeps flowing while the sample output is stalled until the queue and the
// ingress register are full. The decoder extracts the samples of a data word in order and
// keeps a partial sample at the end of a word until the next word completes it. 16-bit
// samples run at one word per cycle while the output is not stalled. The decoder's single
// sample-extraction step and the one-beat-per-cycle output register set this rate. The
// first sample of a data beat passes the ingress register, the queue and the output
// register on its way to the output.
module instrument_packet_sample_unpacker
  import ipsu_pkg::*;
#(
  parameter int MAX_SEGMENTS = ipsu_pkg::MAX_SEGMENTS,
  parameter int CHANNELS     = ipsu_pkg::CHANNELS,
  parameter int COLUMNS      = ipsu_pkg::COLUMNS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // source_id, scan_counter, payload_bytes, data_word, zero padding
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // channel, row, column, sample, zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_pop;
  item_t q_item;

  ipsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .f_valid   (f_valid),
    .f_item    (f_item),
    .f_ready   (f_ready)
  );

  ipsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .head_valid (q_valid),
    .head_item  (q_item),
    .pop        (q_pop)
  );

  ipsu_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .CHANNELS     (CHANNELS),
    .COLUMNS      (COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/ipsu_checker.sv
module ipsu_checker
  import ipsu_pkg::*;
#(
  parameter int CHANNELS = ipsu_pkg::CHANNELS
)
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:0] < 14'(CHANNELS)))
    else $error("channel beyond table");

  // A beat taken without tlast is followed by no valid beat or by the next channel in the same row.
  a_word_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (!out_tvalid || ((out_tdata[13:0] == $past(out_tdata[13:0]) + 14'd1) &&
                       (out_tdata[29:14] == $past(out_tdata[29:14])))))
    else $error("broken sample run within a word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output beat changed while stalled");

endmodule

bind instrument_packet_sample_unpacker ipsu_checker #(.CHANNELS(CHANNELS)) u_ipsu_checker (.*);
